// ===== sv/smtbl_pkg.sv =====
// Package for the sorted insert and merge table: opcodes, FSM state codes,
// transaction payload structs and the per-list control struct. No dependencies.
`default_nettype none
package smtbl_pkg;

    localparam int VALUE_W = 32;

    typedef enum logic [1:0] {
        OP_INS_A = 2'd0,
        OP_INS_B = 2'd1,
        OP_MERGE = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_MERGE = 2'b10
    } state_t;

    typedef struct packed {
        logic [1:0]                opcode;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_out;
        logic                      from_list;
        logic                      status;
        logic                      last;
    } result_t;

    // Per-list control: insert value at its sorted place, or pop the head.
    typedef struct packed {
        logic                      ins;
        logic                      pop;
        logic signed [VALUE_W-1:0] value;
    } list_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/sorted_insert_and_merge_table_core.sv =====
// Top level of the sorted insert and merge table: two cell-row lists and merge FSM.
// Depends on smtbl_pkg, smtbl_list and smtbl_cell.
`default_nettype none
// Usage:
//   Command channel: a transaction is taken at a rising edge with start high
//   and busy low. cmd.opcode selects insert into list A, insert into list B,
//   or merge; the unused opcode is taken and ignored.
//   Result channel: result_valid marks result for exactly one cycle; there is
//   no backpressure, the receiver must take every result as it comes.
// Timing:
//   An insert completes in the accept cycle: each cell compares its entry with
//   the new value and the row shifts up by one place in a single step, so a
//   new insert can follow on the next cycle. An insert into a full list emits
//   one result (status=1, last=1) in the cycle after acceptance.
//   A merge with N = count A + count B entries holds busy until all N are popped
//   and, once the FSM is in its merge state, emits one registered result per
//   cycle, the head of each list popping through its cell row; the final one has last=1.
//   A merge of two empty lists emits nothing and does not raise busy.
// Reset:
//   rst_n clears both counts and the FSM; stored entries are not cleared and
//   are never read before they are written.
module sorted_insert_and_merge_table_core #(
    parameter int LIST_DEPTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire smtbl_pkg::cmd_t    cmd,
    output logic                    busy,
    output logic                    result_valid,
    output smtbl_pkg::result_t      result
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    smtbl_pkg::state_t     state_reg;
    smtbl_pkg::state_t     state_next;
    logic                  res_valid_reg;
    logic                  res_valid_next;
    smtbl_pkg::result_t    res_reg;
    smtbl_pkg::result_t    res_next;

    smtbl_pkg::list_ctrl_t ctrl_a;
    smtbl_pkg::list_ctrl_t ctrl_b;

    logic signed [smtbl_pkg::VALUE_W-1:0] head_a;
    logic signed [smtbl_pkg::VALUE_W-1:0] head_b;
    logic [CNT_W-1:0]                     cnt_a;
    logic [CNT_W-1:0]                     cnt_b;
    logic                                 full_a;
    logic                                 full_b;

    logic accept;
    logic take_a;
    logic merge_last;

    assign accept = start && (state_reg == smtbl_pkg::S_IDLE);
    assign busy   = (state_reg == smtbl_pkg::S_MERGE);

    // Merge selection: A wins ties, B used only once A is empty or B's head is strictly smaller.
    assign take_a = (cnt_b == '0) || ((cnt_a != '0) && !(head_b < head_a));
    assign merge_last = take_a ? ((cnt_a == CNT_W'(1)) && (cnt_b == '0))
                               : ((cnt_b == CNT_W'(1)) && (cnt_a == '0));

    smtbl_list #(
        .DEPTH (LIST_DEPTH),
        .CNT_W (CNT_W)
    ) u_list_a (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl_a),
        .head  (head_a),
        .count (cnt_a),
        .full  (full_a)
    );

    smtbl_list #(
        .DEPTH (LIST_DEPTH),
        .CNT_W (CNT_W)
    ) u_list_b (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl_b),
        .head  (head_b),
        .count (cnt_b),
        .full  (full_b)
    );

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        ctrl_a         = '{ins: 1'b0, pop: 1'b0, value: cmd.value};
        ctrl_b         = '{ins: 1'b0, pop: 1'b0, value: cmd.value};

        unique case (state_reg)
            smtbl_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.opcode)
                        smtbl_pkg::OP_INS_A,
                        smtbl_pkg::OP_INS_B:
                        begin
                            if (cmd.opcode == smtbl_pkg::OP_INS_A)
                            begin
                                ctrl_a.ins = !full_a;
                            end
                            else
                            begin
                                ctrl_b.ins = !full_b;
                            end
                            // Full list: drop the value and report it.
                            if ((cmd.opcode == smtbl_pkg::OP_INS_A) ? full_a : full_b)
                            begin
                                res_valid_next     = 1'b1;
                                res_next.value_out = cmd.value;
                                res_next.from_list = cmd.opcode[0];
                                res_next.status    = 1'b1;
                                res_next.last      = 1'b1;
                            end
                        end
                        smtbl_pkg::OP_MERGE:
                        begin
                            if ((cnt_a != '0) || (cnt_b != '0))
                                state_next = smtbl_pkg::S_MERGE;
                        end
                        default:
                        begin
                            // unused opcode: no effect
                        end
                    endcase
                end
            end
            smtbl_pkg::S_MERGE:
            begin
                ctrl_a.pop         = take_a;
                ctrl_b.pop         = !take_a;
                res_valid_next     = 1'b1;
                res_next.value_out = take_a ? head_a : head_b;
                res_next.from_list = !take_a;
                res_next.status    = 1'b0;
                res_next.last      = merge_last;
                if (merge_last)
                    state_next = smtbl_pkg::S_IDLE;
            end
            default:
            begin
                state_next = smtbl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= smtbl_pkg::S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

`ifndef SYNTHESIS
    // A merge in progress always has something left to drain.
    a_merge_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == smtbl_pkg::S_MERGE) |-> ((cnt_a != '0) || (cnt_b != '0)))
        else $error("merge running with both lists empty");

    // The final merged result coincides with the return to idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.status && result.last) |-> !busy)
        else $error("busy still high after last merged result");

    // Merged results come out in ascending signed order.
    a_merge_order: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.status && $past(result_valid)
         && !$past(result.status) && !$past(result.last))
        |-> !($signed(result.value_out) < $signed($past(result.value_out))))
        else $error("merged results out of order");
`endif

endmodule
`default_nettype wire

// ===== sv/smtbl_cell.sv =====
// One storage cell of a sorted list row.
// Depends on smtbl_pkg (list control struct).
`default_nettype none
module smtbl_cell (
    input  wire logic                                clk,
    input  wire smtbl_pkg::list_ctrl_t               ctrl,
    input  wire logic                                occ,
    input  wire logic                                prev_gt,
    input  wire logic signed [smtbl_pkg::VALUE_W-1:0] prev_val,
    input  wire logic signed [smtbl_pkg::VALUE_W-1:0] next_val,
    output logic                                     gt,
    output logic signed [smtbl_pkg::VALUE_W-1:0]     val
);

    logic signed [smtbl_pkg::VALUE_W-1:0] val_reg;
    logic signed [smtbl_pkg::VALUE_W-1:0] val_next;

    // Occupied and not below the incoming value: the new value goes ahead of us.
    assign gt  = occ && !(val_reg < ctrl.value);
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.ins)
        begin
            if (prev_gt)
                val_next = prev_val;        // shift up behind the new value
            else if (gt || !occ)
                val_next = ctrl.value;      // insertion point (or free slot)
        end
        else if (ctrl.pop)
        begin
            val_next = next_val;            // shift down toward the head
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule
`default_nettype wire

// ===== sv/smtbl_list.sv =====
// One sorted list: a row of smtbl_cell instances plus the fill count.
// Depends on smtbl_pkg and smtbl_cell.
`default_nettype none
module smtbl_list #(
    parameter int DEPTH = 32,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire smtbl_pkg::list_ctrl_t               ctrl,
    output logic signed [smtbl_pkg::VALUE_W-1:0]     head,
    output logic [CNT_W-1:0]                         count,
    output logic                                     full
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic signed [smtbl_pkg::VALUE_W-1:0] vals [DEPTH];
    logic                                 gts  [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                                 occ;
            logic                                 prev_gt;
            logic signed [smtbl_pkg::VALUE_W-1:0] prev_val;
            logic signed [smtbl_pkg::VALUE_W-1:0] next_val;

            assign occ = (CNT_W'(i) < count_reg);

            if (i == 0)
            begin : g_first
                assign prev_gt  = 1'b0;
                assign prev_val = vals[0];
            end
            else
            begin : g_mid
                assign prev_gt  = gts[i-1];
                assign prev_val = vals[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_end
                assign next_val = vals[i];
            end
            else
            begin : g_nxt
                assign next_val = vals[i+1];
            end

            smtbl_cell u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .occ      (occ),
                .prev_gt  (prev_gt),
                .prev_val (prev_val),
                .next_val (next_val),
                .gt       (gts[i]),
                .val      (vals[i])
            );
        end
    endgenerate

    assign head  = vals[0];
    assign count = count_reg;
    assign full  = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins)
            count_next = count_reg + CNT_W'(1);
        else if (ctrl.pop)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule
`default_nettype wire

// ===== tb/sorted_insert_and_merge_table_core_tb.sv =====
// Testbench for sorted_insert_and_merge_table_core: directed and random command
// streams checked against a behavioral model of the two sorted lists.
// Depends on smtbl_pkg and the core RTL.
`timescale 1ns / 100ps
module sorted_insert_and_merge_table_core_tb;

    localparam int DEPTH       = 32;
    localparam int CYCLE_LIMIT = 400000;  // watchdog, far above the slowest legal run
    localparam int DRAIN_LIMIT = 2000;    // wait for outstanding results at the end
    localparam int TAIL_CYCLES = 80;      // longer than a full 64-entry merge

    // Opcode three is not in the package enum; the core takes it and drops it.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               start;
    smtbl_pkg::cmd_t    cmd;
    logic               busy;
    logic               result_valid;
    smtbl_pkg::result_t result;

    sorted_insert_and_merge_table_core #(
        .LIST_DEPTH(DEPTH)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .busy        (busy),
        .result_valid(result_valid),
        .result      (result)
    );

    // Model state: index 0 is list A, index 1 is list B, kept in ascending order.
    logic signed [smtbl_pkg::VALUE_W-1:0] list_vals [0:1][0:DEPTH-1];
    int                                   list_len  [0:1];

    // Results the core still owes, oldest first.
    smtbl_pkg::result_t pending_results[$];

    int err_count      = 0;
    int cycle_count    = 0;
    int sent_items     = 0;
    int merges_sent    = 0;
    int results_seen   = 0;
    int drops_seen     = 0;
    int ignored_items  = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake or a missing result ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("sorted_insert_and_merge_table_core_tb NOT OK");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Model
    //------------------------------------------------------------------

    // Insert ahead of the first entry >= v; a full list drops v and reports it.
    function automatic void predict_insert(input int sel,
                                           input logic signed [smtbl_pkg::VALUE_W-1:0] v);
        int                 n;
        int                 pos;
        int                 k;
        smtbl_pkg::result_t r;
        n = list_len[sel];
        if (n >= DEPTH)
        begin
            r.value_out = v;
            r.from_list = sel[0];
            r.status    = 1'b1;
            r.last      = 1'b1;
            pending_results.push_back(r);
        end
        else
        begin
            pos = 0;
            while (pos < n && list_vals[sel][pos] < v)
                pos++;
            for (k = n; k > pos; k--)
                list_vals[sel][k] = list_vals[sel][k-1];
            list_vals[sel][pos] = v;
            list_len[sel] = n + 1;
        end
    endfunction

    // Two-way merge, A wins ties; both lists are empty afterward.
    function automatic void predict_merge();
        int                 ia;
        int                 ib;
        int                 na;
        int                 nb;
        bit                 take_a;
        smtbl_pkg::result_t r;
        na = list_len[0];
        nb = list_len[1];
        ia = 0;
        ib = 0;
        while (ia < na || ib < nb)
        begin
            take_a = (ib >= nb) || (ia < na && !(list_vals[1][ib] < list_vals[0][ia]));
            if (take_a)
            begin
                r.value_out = list_vals[0][ia];
                r.from_list = 1'b0;
                ia++;
            end
            else
            begin
                r.value_out = list_vals[1][ib];
                r.from_list = 1'b1;
                ib++;
            end
            r.status = 1'b0;
            r.last   = (ia >= na && ib >= nb);
            pending_results.push_back(r);
        end
        list_len[0] = 0;
        list_len[1] = 0;
    endfunction

    function automatic void predict_cmd(input smtbl_pkg::cmd_t c);
        case (c.opcode)
            smtbl_pkg::OP_INS_A: predict_insert(0, c.value);
            smtbl_pkg::OP_INS_B: predict_insert(1, c.value);
            smtbl_pkg::OP_MERGE: predict_merge();
            default:             ignored_items++;
        endcase
    endfunction

    //------------------------------------------------------------------
    // Result checker: every strobe is matched against the oldest expectation.
    // Sampled at the edge that ends the result cycle.
    //------------------------------------------------------------------
    always @(posedge clk)
    begin
        smtbl_pkg::result_t exp_r;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: value_out %0d from_list %0b status %0b last %0b",
                       result.value_out, result.from_list, result.status, result.last);
                err_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                results_seen++;
                if (exp_r.status)
                    drops_seen++;
                if (result.value_out !== exp_r.value_out)
                begin
                    $error("value_out mismatch: expected %0d, actual %0d",
                           exp_r.value_out, result.value_out);
                    err_count++;
                end
                if (result.from_list !== exp_r.from_list)
                begin
                    $error("from_list mismatch: expected %0b, actual %0b",
                           exp_r.from_list, result.from_list);
                    err_count++;
                end
                if (result.status !== exp_r.status)
                begin
                    $error("status mismatch: expected %0b, actual %0b",
                           exp_r.status, result.status);
                    err_count++;
                end
                if (result.last !== exp_r.last)
                begin
                    $error("last mismatch: expected %0b, actual %0b",
                           exp_r.last, result.last);
                    err_count++;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Stimulus helpers. Every task returns just after a rising edge, and start
    // is left high after a transaction so back-to-back sends never touch it
    // twice in one time step.
    //------------------------------------------------------------------

    // Present one command and hold it until the core takes it (start & !busy).
    task automatic send_cmd(input logic [1:0] op,
                            input logic signed [smtbl_pkg::VALUE_W-1:0] v);
        smtbl_pkg::cmd_t c;
        c.opcode = op;
        c.value  = v;
        start <= 1'b1;
        cmd   <= c;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        predict_cmd(c);
        if (op != OP_UNUSED)
            sent_items++;
        if (op == smtbl_pkg::OP_MERGE)
            merges_sent++;
    endtask

    // Drop start and put junk on the command bus, for a span set by n.
    task automatic idle_cycles(input int n);
        smtbl_pkg::cmd_t junk;
        junk.opcode = 2'($urandom_range(0, 3));
        junk.value  = $urandom;
        start <= 1'b0;
        cmd   <= junk;
        repeat (n) @(posedge clk);
    endtask

    task automatic maybe_idle();
        if ($urandom_range(0, 3) == 0)
            idle_cycles($urandom_range(1, 7));
    endtask

    // Hold off the next command until the core has delivered everything owed.
    task automatic wait_drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Mix of extremes, a tight band around zero for ties, and full-range noise.
    function automatic logic signed [smtbl_pkg::VALUE_W-1:0] pick_value();
        int t;
        t = $urandom_range(0, 6);
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(smtbl_pkg::VALUE_W-1){1'b0}}};
            1:       return {1'b0, {(smtbl_pkg::VALUE_W-1){1'b1}}};
            2, 3:    return t - 3;
            default: return $urandom;
        endcase
    endfunction

    // A batch of inserts (with a little noise) closed by a merge.
    task automatic run_round(input int n_ins, input int a_pct, input bit idling);
        int         i;
        int         pick;
        logic [1:0] op;
        for (i = 0; i < n_ins; i++)
        begin
            pick = $urandom_range(0, 39);
            if (pick < 37)
                op = ($urandom_range(0, 99) < a_pct) ? smtbl_pkg::OP_INS_A
                                                     : smtbl_pkg::OP_INS_B;
            else if (pick < 39)
                op = OP_UNUSED;
            else
                op = smtbl_pkg::OP_MERGE;    // early merge breaks the batch in two
            send_cmd(op, pick_value());
            if (idling)
                maybe_idle();
        end
        send_cmd(smtbl_pkg::OP_MERGE, pick_value());
        if (idling)
            maybe_idle();
    endtask

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // Merge with nothing stored, and the unused opcode, must both stay silent.
    task automatic test_empty_and_unused();
        send_cmd(smtbl_pkg::OP_MERGE, 32'sd0);
        maybe_idle();
        send_cmd(OP_UNUSED, {1'b0, {(smtbl_pkg::VALUE_W-1){1'b1}}});
        send_cmd(smtbl_pkg::OP_MERGE, {1'b1, {(smtbl_pkg::VALUE_W-1){1'b0}}});
        wait_drain();
    endtask

    // Signed extremes, duplicates within a list, and ties across lists.
    task automatic test_extremes_and_ties();
        send_cmd(smtbl_pkg::OP_INS_A, {1'b0, {(smtbl_pkg::VALUE_W-1){1'b1}}});
        send_cmd(smtbl_pkg::OP_INS_A, {1'b1, {(smtbl_pkg::VALUE_W-1){1'b0}}});
        send_cmd(smtbl_pkg::OP_INS_A, 32'sd0);
        send_cmd(smtbl_pkg::OP_INS_B, 32'sd0);
        send_cmd(smtbl_pkg::OP_INS_B, {1'b1, {(smtbl_pkg::VALUE_W-1){1'b0}}});
        maybe_idle();
        send_cmd(smtbl_pkg::OP_INS_B, {1'b0, {(smtbl_pkg::VALUE_W-1){1'b1}}});
        send_cmd(smtbl_pkg::OP_INS_B, -32'sd1);
        send_cmd(OP_UNUSED, 32'sd5);
        send_cmd(smtbl_pkg::OP_INS_A, 32'sd0);
        send_cmd(smtbl_pkg::OP_MERGE, 32'sd0);
        wait_drain();
        // one side empty in each direction
        send_cmd(smtbl_pkg::OP_INS_B, 32'sd7);
        send_cmd(smtbl_pkg::OP_INS_B, -32'sd7);
        send_cmd(smtbl_pkg::OP_MERGE, 32'sd0);
        send_cmd(smtbl_pkg::OP_INS_A, -32'sd1);
        send_cmd(smtbl_pkg::OP_MERGE, 32'sd0);
        wait_drain();
    endtask

    // Fill both lists, overflow each, then drain the largest merge.
    task automatic test_full_lists();
        int i;
        for (i = 0; i < DEPTH + 2; i++)
        begin
            send_cmd(smtbl_pkg::OP_INS_A, pick_value());
            maybe_idle();
        end
        for (i = 0; i < DEPTH + 1; i++)
        begin
            send_cmd(smtbl_pkg::OP_INS_B, pick_value());
            maybe_idle();
        end
        send_cmd(smtbl_pkg::OP_MERGE, 32'sd0);
        send_cmd(smtbl_pkg::OP_INS_A, 32'sd1);   // queued behind the merge
        send_cmd(smtbl_pkg::OP_MERGE, 32'sd0);
        wait_drain();
    endtask

    task automatic test_random_rounds(input int target, input bit idling_allowed);
        int n;
        int a_pct;
        bit idling;
        while (sent_items < target)
        begin
            // some rounds run without any idling at all
            idling = idling_allowed && ($urandom_range(0, 9) < 7);
            if ($urandom_range(0, 7) == 0)
            begin
                // heavy round skewed to one list so it usually fills up
                n     = $urandom_range(33, 45);
                a_pct = $urandom_range(0, 1) ? 92 : 8;
            end
            else
            begin
                n     = $urandom_range(0, 10);
                a_pct = 50;
            end
            run_round(n, a_pct, idling);
            if (idling_allowed && $urandom_range(0, 9) == 0)
                wait_drain();
        end
    endtask

    //------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------
    initial
    begin
        int waited;
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        list_len[0] = 0;
        list_len[1] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_and_unused();
        test_extremes_and_ties();
        test_full_lists();
        test_random_rounds(400, 1'b1);
        test_random_rounds(460, 1'b0);    // closing stretch, no idling

        start <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        // any stray strobe in this window is flagged by the checker
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            err_count++;
        end

        $display("covered %0d commands (%0d merges, %0d ignored opcodes) in %0d cycles",
                 sent_items, merges_sent, ignored_items, cycle_count);
        $display("checked %0d results, %0d of them dropped inserts; %0d errors",
                 results_seen, drops_seen, err_count);
        if (err_count == 0)
            $display("sorted_insert_and_merge_table_core_tb OK");
        else
            $display("sorted_insert_and_merge_table_core_tb NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/smtbl_pkg.sv
sv/smtbl_cell.sv
sv/smtbl_list.sv
sv/sorted_insert_and_merge_table_core.sv
tb/sorted_insert_and_merge_table_core_tb.sv
